>>> rtl/ppd_pkg.sv
// Shared types and constants for the pressure peak event detector.
// No dependencies; every other file refers to it by scoped names.
package ppd_pkg;

    // Field widths.
    localparam int TIME_W   = 31;
    localparam int CHAN_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int MAG_W    = VALUE_W + 1;
    localparam int SEC_W    = 22;
    localparam int THRESH_W = 15;
    localparam int HOLD_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DETECTION_OFF = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [THRESH_W-1:0] THRESHOLD_RST = 15'd100;
    localparam logic [HOLD_W-1:0]   HOLDOFF_RST   = 16'd5000;

    // Sign codes kept per channel after an event.
    typedef logic [1:0] sign_t;
    localparam sign_t SIGN_NONE  = 2'd0;
    localparam sign_t SIGN_PLUS  = 2'd1;
    localparam sign_t SIGN_MINUS = 2'd3;

    // Millisecond to second conversion: drop three low bits (divide by 8),
    // then multiply by a rounded-up reciprocal of the odd part (125).
    localparam int MS_PER_S  = 1000;
    localparam int DIV_PRE   = 3;
    localparam int DIV_ODD   = MS_PER_S >> DIV_PRE;
    localparam int DIVIDEND_W = TIME_W - DIV_PRE;
    localparam int RECIP_SHIFT = DIVIDEND_W + 7;
    localparam int RECIP_W   = 29;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
    localparam int PROD_W    = DIVIDEND_W + RECIP_W;

endpackage

>>> rtl/ppd_if.sv
// Valid/ready channel interfaces for samples in and events out.
// Depends on ppd_pkg for the field widths.
interface ppd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [ppd_pkg::TIME_W-1:0]           time_ms;
    logic [ppd_pkg::CHAN_W-1:0]           channel;
    logic signed [ppd_pkg::VALUE_W-1:0]   pressure_value;

    modport source (output valid, output time_ms, output channel,
                    output pressure_value, input ready);
    modport sink   (input valid, input time_ms, input channel,
                    input pressure_value, output ready);
endinterface

interface ppd_event_if;
    logic                                 valid;
    logic                                 ready;
    logic [ppd_pkg::SEC_W-1:0]            event_seconds;
    logic [ppd_pkg::CHAN_W-1:0]           event_channel;
    logic signed [ppd_pkg::VALUE_W-1:0]   peak_value;

    modport source (output valid, output event_seconds, output event_channel,
                    output peak_value, input ready);
    modport sink   (input valid, input event_seconds, input event_channel,
                    input peak_value, output ready);
endinterface

>>> rtl/ppd_ms_to_sec.sv
// Millisecond to second conversion by reciprocal multiplication.
// Depends on ppd_pkg for widths and the reciprocal constant.
module ppd_ms_to_sec (
    input  logic [ppd_pkg::TIME_W-1:0] time_ms,
    output logic [ppd_pkg::SEC_W-1:0]  seconds
);

    logic [ppd_pkg::DIVIDEND_W-1:0] dividend;
    logic [ppd_pkg::PROD_W-1:0]     product;

    // Exact for every 28-bit dividend: the reciprocal error times the
    // largest dividend stays below one unit of the shift.
    assign dividend = time_ms[ppd_pkg::TIME_W-1:ppd_pkg::DIV_PRE];
    assign product  = ppd_pkg::PROD_W'(dividend) * ppd_pkg::PROD_W'(ppd_pkg::RECIP);
    assign seconds  = product[ppd_pkg::RECIP_SHIFT +: ppd_pkg::SEC_W];

endmodule

>>> rtl/pressure_peak_event_detector.sv
// Pressure peak event detector: top level.
// An accepted item passes from the input register into the event register.
// Throughput: one sample per cycle; the event register stalls the input
// register only while an event waits and the sink is not ready.
// Reset (rst_n low, asynchronous): pipeline empty, idle, all holdoffs clear,
// configuration back to threshold 100, holdoff 5000 ms, detection on.
module pressure_peak_event_detector #(
    parameter int CHANNELS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ppd_sample_if.sink                    samples,
    ppd_event_if.source                   events,
    input  logic                          wr_en,
    input  logic [ppd_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [ppd_pkg::CFG_W-1:0]     wr_data
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ppd_pkg::THRESH_W-1:0] threshold_reg;
    logic [ppd_pkg::HOLD_W-1:0]   holdoff_reg;
    logic                         detection_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= ppd_pkg::THRESHOLD_RST;
            holdoff_reg       <= ppd_pkg::HOLDOFF_RST;
            detection_off_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ppd_pkg::REG_THRESHOLD:     threshold_reg <= wr_data[ppd_pkg::THRESH_W-1:0];
                ppd_pkg::REG_HOLDOFF_MS:    holdoff_reg   <= wr_data[ppd_pkg::HOLD_W-1:0];
                ppd_pkg::REG_DETECTION_OFF: detection_off_reg <= wr_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic                               in_valid_reg;
    logic [ppd_pkg::TIME_W-1:0]         time_reg;
    logic [ppd_pkg::CHAN_W-1:0]         chan_reg;
    logic signed [ppd_pkg::VALUE_W-1:0] value_reg;

    logic out_valid_reg;
    logic advance;

    // Move the held item on when the event register is free or draining.
    assign advance       = in_valid_reg && (!out_valid_reg || events.ready);
    assign samples.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            in_valid_reg <= samples.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (samples.ready && samples.valid)
        begin
            time_reg  <= samples.time_ms;
            chan_reg  <= samples.channel;
            value_reg <= samples.pressure_value;
        end
    end

    // ---------------------------------------------------------------
    // Detector state
    // ---------------------------------------------------------------
    logic                               tracking_reg, tracking_next;
    logic [ppd_pkg::CHAN_W-1:0]         watched_ch_reg, watched_ch_next;
    logic                               watched_valid_reg, watched_valid_next;
    logic signed [ppd_pkg::VALUE_W-1:0] prev_reg, prev_next;
    logic [ppd_pkg::TIME_W-1:0]         base_reg [CHANNELS];
    ppd_pkg::sign_t                     sign_reg [CHANNELS];

    logic [CH_IDX_W-1:0]                ch_idx;
    logic                               ch_ok;
    logic                               take;
    logic [ppd_pkg::MAG_W-1:0]          mag_p;
    logic [ppd_pkg::MAG_W-1:0]          mag_prev;
    logic [ppd_pkg::TIME_W:0]           hold_limit;
    ppd_pkg::sign_t                     ch_sign;
    logic                               hold_active;
    logic                               same_sign;
    logic                               held;
    logic                               start;
    logic                               on_watched;
    logic                               emit;

    assign ch_idx = CH_IDX_W'(chan_reg);
    assign ch_ok  = {30'd0, chan_reg} < 32'(CHANNELS);
    assign take   = advance && !detection_off_reg && ch_ok;

    // Magnitudes at 17 bits so the most negative sample reads as 32768.
    assign mag_p    = value_reg[ppd_pkg::VALUE_W-1]
                    ? -ppd_pkg::MAG_W'(value_reg) : ppd_pkg::MAG_W'(value_reg);
    assign mag_prev = prev_reg[ppd_pkg::VALUE_W-1]
                    ? -ppd_pkg::MAG_W'(prev_reg) : ppd_pkg::MAG_W'(prev_reg);

    // Holdoff window: sum kept one bit wider, so it never wraps.
    assign ch_sign     = ch_ok ? sign_reg[ch_idx] : ppd_pkg::SIGN_NONE;
    assign hold_limit  = (ch_ok ? {1'b0, base_reg[ch_idx]} : '0)
                       + (ppd_pkg::TIME_W+1)'(holdoff_reg);
    assign hold_active = {1'b0, time_reg} < hold_limit;
    // A zero sample never matches either sign.
    assign same_sign   = ((ch_sign == ppd_pkg::SIGN_PLUS)  && (value_reg > 0))
                      || ((ch_sign == ppd_pkg::SIGN_MINUS) && (value_reg < 0));
    assign held        = hold_active && same_sign;

    // Idle and above threshold: start tracking this channel.
    assign start      = take && !held && !tracking_reg
                      && (mag_p > ppd_pkg::MAG_W'(threshold_reg));
    // Otherwise only the watched channel matters.
    assign on_watched = take && !held && !start && watched_valid_reg
                      && (watched_ch_reg == chan_reg);
    // First fall in magnitude while tracking: the previous sample was the peak.
    assign emit       = on_watched && tracking_reg && (mag_p < mag_prev);

    always_comb
    begin
        tracking_next      = tracking_reg;
        watched_ch_next    = watched_ch_reg;
        watched_valid_next = watched_valid_reg;
        prev_next          = prev_reg;
        if (start)
        begin
            tracking_next      = 1'b1;
            watched_ch_next    = chan_reg;
            watched_valid_next = 1'b1;
            prev_next          = value_reg;
        end
        else if (on_watched)
        begin
            prev_next = value_reg;
            if (emit)
            begin
                tracking_next      = 1'b0;
                watched_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg      <= 1'b0;
            watched_ch_reg    <= '0;
            watched_valid_reg <= 1'b1;
            prev_reg          <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                base_reg[i] <= '0;
                sign_reg[i] <= ppd_pkg::SIGN_NONE;
            end
        end
        else
        begin
            tracking_reg      <= tracking_next;
            watched_ch_reg    <= watched_ch_next;
            watched_valid_reg <= watched_valid_next;
            prev_reg          <= prev_next;
            // Arm the channel's holdoff with the sign of the peak.
            if (emit)
            begin
                base_reg[ch_idx] <= time_reg;
                sign_reg[ch_idx] <= (prev_reg > 0) ? ppd_pkg::SIGN_PLUS
                                                   : ppd_pkg::SIGN_MINUS;
            end
        end
    end

    // ---------------------------------------------------------------
    // Event register
    // ---------------------------------------------------------------
    logic [ppd_pkg::SEC_W-1:0]          seconds;
    logic [ppd_pkg::SEC_W-1:0]          out_sec_reg;
    logic [ppd_pkg::CHAN_W-1:0]         out_chan_reg;
    logic signed [ppd_pkg::VALUE_W-1:0] out_peak_reg;

    ppd_ms_to_sec u_ms_to_sec (
        .time_ms (time_reg),
        .seconds (seconds)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (events.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_sec_reg  <= seconds;
            out_chan_reg <= chan_reg;
            out_peak_reg <= prev_reg;
        end
    end

    assign events.valid         = out_valid_reg;
    assign events.event_seconds = out_sec_reg;
    assign events.event_channel = out_chan_reg;
    assign events.peak_value    = out_peak_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Tracking always has a watched channel.
    a_track_watched: assert property (@(posedge clk) disable iff (!rst_n)
        tracking_reg |-> watched_valid_reg)
        else $error("tracking without a watched channel");

    // An event ends tracking and drops the watched channel.
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !tracking_reg && !watched_valid_reg)
        else $error("event did not return the detector to idle");

    // An event register fill comes from an item that advanced.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance))
        else $error("event appeared without an item");

    // A stalled item in the input register is neither lost nor changed.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(time_reg)
            && $stable(chan_reg) && $stable(value_reg))
        else $error("stalled item overwritten");

    // A waiting event is never replaced before the sink takes it.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !events.ready) |=> out_valid_reg && $stable(out_sec_reg)
            && $stable(out_peak_reg))
        else $error("pending event overwritten");

endmodule
